@@ sv/pmd_pkg.sv @@
// ----------------------------------------------------------------------------
// pmd_pkg: shared types and constants for the projection matrix decomposer.
// Holds the data widths, result kind codes and the pipelined divider's
// per-lane stage record with its single-step function.
// ----------------------------------------------------------------------------
package pmd_pkg;

   // Width of every matrix entry and every result value.
   localparam int Q_W = 32;
   // Dividend and divisor widths used by the divider pipelines.
   localparam int NUM_W = 2 * Q_W;
   localparam int DEN_W = Q_W + 1;
   // Default number of fraction bits of the fixed-point format.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Result kind codes.
   typedef enum logic [1:0] {
      KIND_ORTHO   = 2'd0,
      KIND_PERSP   = 2'd1,
      KIND_UNKNOWN = 2'd2
   } kind_type;

   // One lane of one divider stage.
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [Q_W-1:0]   low;
      logic [DEN_W-1:0] dmag;
      logic [Q_W-1:0]   quo;
      logic             neg;
      logic             num_pos;
      logic             num_neg;
      logic             zden;
      logic             big;
   } div_lane_type;

   // One restoring division step: bring in the next dividend bit and
   // subtract the divisor when it fits.
   function automatic div_lane_type div_step(input div_lane_type x);
      div_lane_type     y;
      logic [DEN_W:0]   cur;
      logic [DEN_W+1:0] diff;
      y     = x;
      cur   = {x.rem, x.low[Q_W-1]};
      diff  = {1'b0, cur} - {2'b00, x.dmag};
      y.low = {x.low[Q_W-2:0], 1'b0};
      if (!diff[DEN_W+1]) begin
         y.rem = diff[DEN_W-1:0];
         y.quo = {x.quo[Q_W-2:0], 1'b1};
      end else begin
         y.rem = cur[DEN_W-1:0];
         y.quo = {x.quo[Q_W-2:0], 1'b0};
      end
      return y;
   endfunction

endpackage

@@ sv/projection_matrix_decompose.sv @@
// ----------------------------------------------------------------------------
// projection_matrix_decompose: view volume recovery from a projection matrix.
// Classifies a column-major projection matrix by its bottom row and recovers
// near, far, top, bottom, left and right bounds of the view volume in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries the ten matrix entries of one transaction; the
//   rsp_ channel returns one result transaction per request, in order.
//   Both channels use valid/ready; a transaction moves when both are high.
//   A request passes the input, classification, near/far divider, edge
//   operand, edge divider and output registers before rsp_valid rises. A new
//   transaction is taken every cycle unless the output stalls. Each divider
//   bank forms one quotient bit per stage after magnitude and overflow
//   stages; the second is fed by a stage that multiplies near for perspective.
//   When the receiver holds rsp_ready low with a result waiting, the whole
//   pipeline freezes and req_ready drops in the same cycle; nothing is lost
//   or repeated. A synchronous reset empties the pipeline; results in flight
//   are dropped and rsp_valid is low after reset.
//   Division by zero and quotient overflow saturate and set divide_fault.
// ----------------------------------------------------------------------------
module projection_matrix_decompose
   import pmd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [Q_W-1:0] req_scale_x,
   input  logic signed [Q_W-1:0] req_scale_y,
   input  logic signed [Q_W-1:0] req_skew_x,
   input  logic signed [Q_W-1:0] req_skew_y,
   input  logic signed [Q_W-1:0] req_depth_scale,
   input  logic signed [Q_W-1:0] req_w_from_z,
   input  logic signed [Q_W-1:0] req_offset_x,
   input  logic signed [Q_W-1:0] req_offset_y,
   input  logic signed [Q_W-1:0] req_depth_offset,
   input  logic signed [Q_W-1:0] req_w_constant,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_volume_kind,
   output logic signed [Q_W-1:0] rsp_near_plane,
   output logic signed [Q_W-1:0] rsp_far_plane,
   output logic signed [Q_W-1:0] rsp_top_edge,
   output logic signed [Q_W-1:0] rsp_bottom_edge,
   output logic signed [Q_W-1:0] rsp_left_edge,
   output logic signed [Q_W-1:0] rsp_right_edge,
   output logic                  rsp_divide_fault
);

   localparam logic signed [DEN_W-1:0] ONE = DEN_W'(1) << FRAC_BITS;

   // Items carried past the first divider bank.
   typedef struct packed {
      kind_type              kind;
      logic signed [Q_W-1:0] sxx;
      logic signed [Q_W-1:0] syy;
      logic signed [Q_W-1:0] kx;
      logic signed [Q_W-1:0] ky;
      logic signed [Q_W-1:0] ox;
      logic signed [Q_W-1:0] oy;
   } side1_type;

   // Items carried past the second divider bank.
   typedef struct packed {
      kind_type       kind;
      logic [Q_W-1:0] near_q;
      logic [Q_W-1:0] far_q;
      logic           fault;
   } side2_type;

   logic en;

   // Input register.
   logic                  s0_vld_ff;
   logic signed [Q_W-1:0] s0_sxx_ff, s0_syy_ff, s0_kx_ff, s0_ky_ff, s0_dz_ff;
   logic signed [Q_W-1:0] s0_wz_ff, s0_ox_ff, s0_oy_ff, s0_doff_ff, s0_wc_ff;

   // Classification and near/far operands.
   kind_type                   s1_kind_in;
   logic [1:0][NUM_W-1:0]      s1_num_in;
   logic [1:0][DEN_W-1:0]      s1_den_in;
   logic                       s1_vld_ff;
   side1_type                  s1_side_ff;
   logic [1:0][NUM_W-1:0]      s1_num_ff;
   logic [1:0][DEN_W-1:0]      s1_den_ff;

   // First divider bank outputs.
   logic                       d1_vld;
   side1_type                  d1_side;
   logic [1:0][Q_W-1:0]        d1_quo;
   logic [1:0]                 d1_fault;

   // Edge operand stage.
   logic [3:0][NUM_W-1:0]      m_num_in;
   logic [3:0][DEN_W-1:0]      m_den_in;
   logic                       m_vld_ff;
   side2_type                  m_side_ff;
   logic [3:0][NUM_W-1:0]      m_num_ff;
   logic [3:0][DEN_W-1:0]      m_den_ff;

   // Second divider bank outputs.
   logic                       d2_vld;
   side2_type                  d2_side;
   logic [3:0][Q_W-1:0]        d2_quo;
   logic [3:0]                 d2_fault;

   // Output register.
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_kind_ff;
   logic [Q_W-1:0]        rsp_near_ff, rsp_far_ff, rsp_top_ff, rsp_bot_ff;
   logic [Q_W-1:0]        rsp_left_ff, rsp_right_ff;
   logic                  rsp_fault_ff;

   // The pipeline advances whenever the output register is free or drains.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Classification by the bottom row and near/far operands.
   always_comb begin
      logic signed [DEN_W-1:0] doff;
      logic signed [DEN_W-1:0] dz;
      doff = DEN_W'(s0_doff_ff);
      dz   = DEN_W'(s0_dz_ff);
      if (s0_wz_ff == '0 && DEN_W'(s0_wc_ff) == ONE) begin
         s1_kind_in   = KIND_ORTHO;
         s1_num_in[0] = NUM_W'(doff + ONE) << FRAC_BITS;
         s1_num_in[1] = NUM_W'(doff - ONE) << FRAC_BITS;
         s1_den_in[0] = dz;
         s1_den_in[1] = dz;
      end else begin
         s1_kind_in = (DEN_W'(s0_wz_ff) == -ONE && s0_wc_ff == '0) ? KIND_PERSP
                                                                   : KIND_UNKNOWN;
         s1_num_in[0] = NUM_W'(s0_doff_ff) << FRAC_BITS;
         s1_num_in[1] = NUM_W'(s0_doff_ff) << FRAC_BITS;
         s1_den_in[0] = dz - ONE;
         s1_den_in[1] = dz + ONE;
      end
   end

   // Edge operands: scaled near products for perspective, offsets for ortho.
   always_comb begin
      logic signed [DEN_W-1:0] kxm, kxp, kym, kyp;
      logic signed [Q_W-1:0]   nq;
      logic signed [NUM_W:0]   p_top, p_bot, p_left, p_right;
      logic signed [DEN_W-1:0] ox, oy;
      kxm     = DEN_W'(d1_side.kx) - ONE;
      kxp     = DEN_W'(d1_side.kx) + ONE;
      kym     = DEN_W'(d1_side.ky) - ONE;
      kyp     = DEN_W'(d1_side.ky) + ONE;
      nq      = d1_quo[0];
      p_top   = nq * kyp;
      p_bot   = nq * kym;
      p_left  = nq * kxm;
      p_right = nq * kxp;
      ox      = DEN_W'(d1_side.ox);
      oy      = DEN_W'(d1_side.oy);
      if (d1_side.kind == KIND_ORTHO) begin
         m_num_in[0] = NUM_W'(ONE - oy) << FRAC_BITS;
         m_num_in[1] = NUM_W'(-ONE - oy) << FRAC_BITS;
         m_num_in[2] = NUM_W'(-ONE - ox) << FRAC_BITS;
         m_num_in[3] = NUM_W'(ONE - ox) << FRAC_BITS;
      end else begin
         m_num_in[0] = p_top[NUM_W-1:0];
         m_num_in[1] = p_bot[NUM_W-1:0];
         m_num_in[2] = p_left[NUM_W-1:0];
         m_num_in[3] = p_right[NUM_W-1:0];
      end
      m_den_in[0] = DEN_W'(d1_side.syy);
      m_den_in[1] = DEN_W'(d1_side.syy);
      m_den_in[2] = DEN_W'(d1_side.sxx);
      m_den_in[3] = DEN_W'(d1_side.sxx);
   end

   // Stage valid bits and the output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff    <= req_valid;
         s1_vld_ff    <= s0_vld_ff;
         m_vld_ff     <= d1_vld;
         rsp_valid_ff <= d2_vld;
      end
   end

   // Stage data registers.
   always_ff @(posedge clock) begin
      if (en) begin
         s0_sxx_ff  <= req_scale_x;
         s0_syy_ff  <= req_scale_y;
         s0_kx_ff   <= req_skew_x;
         s0_ky_ff   <= req_skew_y;
         s0_dz_ff   <= req_depth_scale;
         s0_wz_ff   <= req_w_from_z;
         s0_ox_ff   <= req_offset_x;
         s0_oy_ff   <= req_offset_y;
         s0_doff_ff <= req_depth_offset;
         s0_wc_ff   <= req_w_constant;

         s1_side_ff <= '{kind: s1_kind_in, sxx: s0_sxx_ff, syy: s0_syy_ff,
                         kx: s0_kx_ff, ky: s0_ky_ff, ox: s0_ox_ff, oy: s0_oy_ff};
         s1_num_ff  <= s1_num_in;
         s1_den_ff  <= s1_den_in;

         m_side_ff  <= '{kind: d1_side.kind, near_q: d1_quo[0], far_q: d1_quo[1],
                         fault: d1_fault[0] | d1_fault[1]};
         m_num_ff   <= m_num_in;
         m_den_ff   <= m_den_in;

         // Unknown matrices report zero bounds and no fault.
         rsp_kind_ff <= d2_side.kind;
         if (d2_side.kind == KIND_UNKNOWN) begin
            rsp_near_ff  <= '0;
            rsp_far_ff   <= '0;
            rsp_top_ff   <= '0;
            rsp_bot_ff   <= '0;
            rsp_left_ff  <= '0;
            rsp_right_ff <= '0;
            rsp_fault_ff <= 1'b0;
         end else begin
            rsp_near_ff  <= d2_side.near_q;
            rsp_far_ff   <= d2_side.far_q;
            rsp_top_ff   <= d2_quo[0];
            rsp_bot_ff   <= d2_quo[1];
            rsp_left_ff  <= d2_quo[2];
            rsp_right_ff <= d2_quo[3];
            rsp_fault_ff <= d2_side.fault | (|d2_fault);
         end
      end
   end

   // Near and far division.
   pmd_div #(
      .LANES  (2),
      .SIDE_W ($bits(side1_type))
   ) u_div_depth (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_vld_ff),
      .in_side   (s1_side_ff),
      .in_num    (s1_num_ff),
      .in_den    (s1_den_ff),
      .out_valid (d1_vld),
      .out_side  (d1_side),
      .out_quo   (d1_quo),
      .out_fault (d1_fault)
   );

   // Edge division.
   pmd_div #(
      .LANES  (4),
      .SIDE_W ($bits(side2_type))
   ) u_div_edge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_vld_ff),
      .in_side   (m_side_ff),
      .in_num    (m_num_ff),
      .in_den    (m_den_ff),
      .out_valid (d2_vld),
      .out_side  (d2_side),
      .out_quo   (d2_quo),
      .out_fault (d2_fault)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_volume_kind  = rsp_kind_ff;
   assign rsp_near_plane   = rsp_near_ff;
   assign rsp_far_plane    = rsp_far_ff;
   assign rsp_top_edge     = rsp_top_ff;
   assign rsp_bottom_edge  = rsp_bot_ff;
   assign rsp_left_edge    = rsp_left_ff;
   assign rsp_right_edge   = rsp_right_ff;
   assign rsp_divide_fault = rsp_fault_ff;

endmodule

@@ sv/pmd_div.sv @@
// ----------------------------------------------------------------------------
// pmd_div: pipelined saturating signed divider bank.
// Divides LANES signed dividends by signed divisors, one bit per stage,
// truncating toward zero and saturating to the signed result range. A side
// payload and a valid bit travel alongside. All stages advance on en.
// ----------------------------------------------------------------------------
module pmd_div
   import pmd_pkg::*;
#(
   parameter int LANES  = 2,
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [SIDE_W-1:0]            in_side,
   input  logic [LANES-1:0][NUM_W-1:0]  in_num,
   input  logic [LANES-1:0][DEN_W-1:0]  in_den,
   output logic                         out_valid,
   output logic [SIDE_W-1:0]            out_side,
   output logic [LANES-1:0][Q_W-1:0]    out_quo,
   output logic [LANES-1:0]             out_fault
);

   // Stage 0 takes magnitudes, stage 1 checks overflow, then one bit a stage.
   localparam int STG = Q_W + 2;

   div_lane_type      st_ff [STG][LANES];
   div_lane_type      st_in [STG][LANES];
   logic              vld_ff [STG];
   logic [SIDE_W-1:0] side_ff [STG];

   logic [LANES-1:0][Q_W-1:0] quo_in;
   logic [LANES-1:0]          fault_in;
   logic                      out_valid_ff;
   logic [SIDE_W-1:0]         out_side_ff;
   logic [LANES-1:0][Q_W-1:0] out_quo_ff;
   logic [LANES-1:0]          out_fault_ff;

   // Next value of every stage.
   always_comb begin
      logic [NUM_W-1:0] nmag;
      logic [DEN_W-1:0] dmag;
      for (int l = 0; l < LANES; l++) begin
         nmag = in_num[l][NUM_W-1] ? (~in_num[l] + NUM_W'(1)) : in_num[l];
         dmag = in_den[l][DEN_W-1] ? (~in_den[l] + DEN_W'(1)) : in_den[l];
         st_in[0][l].rem     = {1'b0, nmag[NUM_W-1:Q_W]};
         st_in[0][l].low     = nmag[Q_W-1:0];
         st_in[0][l].dmag    = dmag;
         st_in[0][l].quo     = '0;
         st_in[0][l].neg     = in_num[l][NUM_W-1] ^ in_den[l][DEN_W-1];
         st_in[0][l].num_pos = !in_num[l][NUM_W-1] && (|in_num[l]);
         st_in[0][l].num_neg = in_num[l][NUM_W-1];
         st_in[0][l].zden    = ~|in_den[l];
         st_in[0][l].big     = 1'b0;
         // A quotient of 2^Q_W or more shows in the upper dividend half.
         st_in[1][l]     = st_ff[0][l];
         st_in[1][l].big = (st_ff[0][l].rem >= st_ff[0][l].dmag);
      end
      for (int s = 2; s < STG; s++) begin
         for (int l = 0; l < LANES; l++) begin
            st_in[s][l] = div_step(st_ff[s-1][l]);
         end
      end
   end

   // Sign restore and saturation of the finished quotient.
   always_comb begin
      div_lane_type x;
      for (int l = 0; l < LANES; l++) begin
         x           = st_ff[STG-1][l];
         fault_in[l] = 1'b1;
         if (x.zden) begin
            if (x.num_pos) begin
               quo_in[l] = {1'b0, {(Q_W-1){1'b1}}};
            end else if (x.num_neg) begin
               quo_in[l] = {1'b1, {(Q_W-1){1'b0}}};
            end else begin
               quo_in[l] = '0;
            end
         end else if (x.big) begin
            quo_in[l] = x.neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
         end else if (x.neg) begin
            if (x.quo[Q_W-1] && (|x.quo[Q_W-2:0])) begin
               quo_in[l] = {1'b1, {(Q_W-1){1'b0}}};
            end else begin
               quo_in[l]   = ~x.quo + Q_W'(1);
               fault_in[l] = 1'b0;
            end
         end else if (x.quo[Q_W-1]) begin
            quo_in[l] = {1'b0, {(Q_W-1){1'b1}}};
         end else begin
            quo_in[l]   = x.quo;
            fault_in[l] = 1'b0;
         end
      end
   end

   // Valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STG; s++) begin
            vld_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < STG; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         out_valid_ff <= vld_ff[STG-1];
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      if (en) begin
         st_ff      <= st_in;
         side_ff[0] <= in_side;
         for (int s = 1; s < STG; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         out_side_ff  <= side_ff[STG-1];
         out_quo_ff   <= quo_in;
         out_fault_ff <= fault_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign out_quo   = out_quo_ff;
   assign out_fault = out_fault_ff;

endmodule

@@ sv/pmd_checker.sv @@
// ----------------------------------------------------------------------------
// pmd_checker: port-level checks for the projection matrix decomposer.
// Watches the top level's ports and flags behavior that the pipeline
// should never show; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module pmd_checker
   import pmd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic signed [Q_W-1:0] req_scale_x,
   input logic signed [Q_W-1:0] req_scale_y,
   input logic signed [Q_W-1:0] req_skew_x,
   input logic signed [Q_W-1:0] req_skew_y,
   input logic signed [Q_W-1:0] req_depth_scale,
   input logic signed [Q_W-1:0] req_w_from_z,
   input logic signed [Q_W-1:0] req_offset_x,
   input logic signed [Q_W-1:0] req_offset_y,
   input logic signed [Q_W-1:0] req_depth_offset,
   input logic signed [Q_W-1:0] req_w_constant,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_volume_kind,
   input logic signed [Q_W-1:0] rsp_near_plane,
   input logic signed [Q_W-1:0] rsp_far_plane,
   input logic signed [Q_W-1:0] rsp_top_edge,
   input logic signed [Q_W-1:0] rsp_bottom_edge,
   input logic signed [Q_W-1:0] rsp_left_edge,
   input logic signed [Q_W-1:0] rsp_right_edge,
   input logic                  rsp_divide_fault
);

   // A stalled result transaction holds its kind, near, far and fault values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_near_plane)
         && $stable(rsp_far_plane) && $stable(rsp_volume_kind)
         && $stable(rsp_divide_fault))
      else $error("stalled result changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With no result waiting, the block takes requests.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request stalled with an empty output register");

   // Unknown matrices give zero bounds and no fault.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_volume_kind == KIND_UNKNOWN |->
         rsp_near_plane == '0 && rsp_far_plane == '0 && rsp_top_edge == '0
         && rsp_bottom_edge == '0 && rsp_left_edge == '0 && rsp_right_edge == '0
         && !rsp_divide_fault)
      else $error("unknown kind with nonzero result");

   // The kind code never takes its unused value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_volume_kind == KIND_ORTHO || rsp_volume_kind == KIND_PERSP
         || rsp_volume_kind == KIND_UNKNOWN)
      else $error("invalid kind code");

endmodule

bind projection_matrix_decompose pmd_checker u_pmd_checker (.*);

@@ tb/sv/tb_projection_matrix_decompose.sv @@
// ----------------------------------------------------------------------------
// tb_projection_matrix_decompose: self-checking bench for the decomposer.
// Drives directed and random projection matrices through the request channel,
// predicts each view volume in fixed point and compares every response field
// in order, under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_projection_matrix_decompose;
   import pmd_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam longint ONE = longint'(1) << FRAC;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic signed [31:0] sx, sy, kx, ky, dz, wz, ox, oy, doff, wc;
   } matrix_type;

   typedef struct {
      kind_type kind;
      logic signed [31:0] near_v, far_v, top_v, bot_v, left_v, right_v;
      logic fault;
   } volume_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_scale_x = 0, req_scale_y = 0, req_skew_x = 0, req_skew_y = 0;
   logic signed [31:0] req_depth_scale = 0, req_w_from_z = 0, req_offset_x = 0;
   logic signed [31:0] req_offset_y = 0, req_depth_offset = 0, req_w_constant = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_volume_kind;
   logic signed [31:0] rsp_near_plane, rsp_far_plane, rsp_top_edge, rsp_bottom_edge;
   logic signed [31:0] rsp_left_edge, rsp_right_edge;
   logic rsp_divide_fault;

   matrix_type pending_matrices[$];
   volume_type expected_volumes[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_sender = 0;
   bit stimulus_done = 0;
   int failures = 0;
   int idle_cycles = 0;

   projection_matrix_decompose DUT (.*);

   // Clock generation.
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Divide with saturation; the fault flag is sticky through the caller.
   function automatic longint sat_quotient(longint num, longint den, ref bit fault);
      longint q;
      if (den == 0) begin
         fault = 1;
         return (num > 0) ? QMAX : (num < 0) ? QMIN : 0;
      end
      q = num / den;
      if (q > QMAX) begin
         fault = 1;
         return QMAX;
      end
      if (q < QMIN) begin
         fault = 1;
         return QMIN;
      end
      return q;
   endfunction

   // Predict the view volume that one matrix describes.
   function automatic volume_type decompose_matrix(matrix_type m);
      volume_type v;
      bit fault;
      longint sx, sy, kx, ky, dz, ox, oy, doff, nv;
      fault = 0;
      sx = m.sx; sy = m.sy; kx = m.kx; ky = m.ky; dz = m.dz;
      ox = m.ox; oy = m.oy; doff = m.doff;
      v.near_v = 0; v.far_v = 0; v.top_v = 0; v.bot_v = 0; v.left_v = 0; v.right_v = 0;
      if (m.wz == 0 && longint'(m.wc) == ONE) begin
         v.kind = KIND_ORTHO;
         v.near_v = sat_quotient((ONE + doff) * ONE, dz, fault);
         v.far_v = sat_quotient((doff - ONE) * ONE, dz, fault);
         v.top_v = sat_quotient((ONE - oy) * ONE, sy, fault);
         v.bot_v = sat_quotient((-ONE - oy) * ONE, sy, fault);
         v.left_v = sat_quotient((-ONE - ox) * ONE, sx, fault);
         v.right_v = sat_quotient((ONE - ox) * ONE, sx, fault);
      end else if (longint'(m.wz) == -ONE && m.wc == 0) begin
         v.kind = KIND_PERSP;
         nv = sat_quotient(doff * ONE, dz - ONE, fault);
         v.near_v = nv;
         v.far_v = sat_quotient(doff * ONE, dz + ONE, fault);
         v.bot_v = sat_quotient(nv * (ky - ONE), sy, fault);
         v.top_v = sat_quotient(nv * (ky + ONE), sy, fault);
         v.left_v = sat_quotient(nv * (kx - ONE), sx, fault);
         v.right_v = sat_quotient(nv * (kx + ONE), sx, fault);
      end else begin
         v.kind = KIND_UNKNOWN;
      end
      v.fault = fault;
      return v;
   endfunction

   // Random entry: often small values near one, sometimes any bit pattern.
   function automatic logic signed [31:0] rand_entry();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 0;
         2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         3: return $signed(32'($urandom_range(0, 8 * ONE))) - 32'(4 * ONE);
         default: return $signed(32'($urandom_range(0, 2 * ONE))) - 32'(ONE);
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      int shape;
      m.sx = rand_entry(); m.sy = rand_entry(); m.kx = rand_entry(); m.ky = rand_entry();
      m.dz = rand_entry(); m.ox = rand_entry(); m.oy = rand_entry(); m.doff = rand_entry();
      shape = $urandom_range(0, 9);
      if (shape < 4) begin
         m.wz = 0; m.wc = 32'(ONE);
      end else if (shape < 8) begin
         m.wz = -32'(ONE); m.wc = 0;
      end else begin
         m.wz = rand_entry(); m.wc = rand_entry();
      end
      // Occasionally land exactly on the perspective divisor zeros.
      if ($urandom_range(0, 15) == 0) m.dz = $urandom_range(0, 1) ? 32'(ONE) : -32'(ONE);
      return m;
   endfunction

   function automatic matrix_type make_matrix(logic signed [31:0] s,
                                              logic signed [31:0] k,
                                              logic signed [31:0] d,
                                              logic signed [31:0] o,
                                              logic signed [31:0] wz,
                                              logic signed [31:0] wc);
      matrix_type m;
      m.sx = s; m.sy = s; m.kx = k; m.ky = k; m.dz = d; m.ox = o; m.oy = o;
      m.doff = o; m.wz = wz; m.wc = wc;
      return m;
   endfunction

   task automatic wait_drained();
      while (pending_matrices.size() != 0 || expected_volumes.size() != 0)
         @(posedge clock);
   endtask

   // Stimulus and idling phases.
   initial begin
      logic signed [31:0] pone, mone, hi, lo;
      pone = 32'(ONE); mone = -32'(ONE); hi = 32'sh7FFFFFFF; lo = 32'sh80000000;
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed cases: both kinds, unknown, zero divisors, overflow, extremes.
      pending_matrices.push_back(make_matrix(pone, 0, pone, 0, 0, pone));
      pending_matrices.push_back(make_matrix(pone, 0, -32'(2 * ONE), pone, mone, 0));
      pending_matrices.push_back(make_matrix(0, 0, 0, 0, 0, pone));
      pending_matrices.push_back(make_matrix(0, 0, 0, pone, 0, pone));
      pending_matrices.push_back(make_matrix(0, 0, pone, pone, mone, 0));
      pending_matrices.push_back(make_matrix(pone, pone, mone, hi, mone, 0));
      pending_matrices.push_back(make_matrix(1, hi, hi, hi, 0, pone));
      pending_matrices.push_back(make_matrix(-1, lo, lo, lo, 0, pone));
      pending_matrices.push_back(make_matrix(1, lo, lo, lo, mone, 0));
      pending_matrices.push_back(make_matrix(lo, hi, 1, hi, mone, 0));
      pending_matrices.push_back(make_matrix(hi, lo, -1, lo, 0, pone));
      pending_matrices.push_back(make_matrix(pone, 0, pone, 0, pone, 0));
      pending_matrices.push_back(make_matrix(pone, 0, pone, 0, 0, 0));
      pending_matrices.push_back(make_matrix(hi, hi, hi, hi, hi, hi));
      pending_matrices.push_back(make_matrix(lo, lo, lo, lo, lo, lo));
      pending_matrices.push_back(make_matrix(-1, -1, -1, -1, -1, -1));
      wait_drained();

      // Sender is held while a batch of random matrices is queued.
      hold_sender = 1;
      repeat (100) pending_matrices.push_back(random_matrix());
      hold_sender = 0;
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 73 : 36) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 73 : 36) : 0;
         repeat (135) pending_matrices.push_back(random_matrix());
         wait_drained();
      end
      stimulus_done = 1;
   end

   // Driver: offers the oldest pending matrix, holding it until accepted.
   always @(posedge clock) begin
      matrix_type m;
      bit take;
      if (reset) begin
         req_valid <= 0;
      end else begin
         take = req_valid && req_ready;
         if (take) begin
            expected_volumes.push_back(decompose_matrix(pending_matrices.pop_front()));
         end
         if ((req_valid && !take) ||
             (!hold_sender && pending_matrices.size() != 0 &&
              $urandom_range(0, 99) >= send_idle_pct)) begin
            if (pending_matrices.size() != 0) begin
               m = pending_matrices[0];
               req_valid <= 1;
               req_scale_x <= m.sx; req_scale_y <= m.sy; req_skew_x <= m.kx;
               req_skew_y <= m.ky; req_depth_scale <= m.dz; req_w_from_z <= m.wz;
               req_offset_x <= m.ox; req_offset_y <= m.oy; req_depth_offset <= m.doff;
               req_w_constant <= m.wc;
            end else begin
               req_valid <= 0;
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Monitor: checks each response transaction against the oldest prediction.
   always @(posedge clock) begin
      volume_type e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_volumes.size() == 0) begin
               $error("unexpected response transaction");
               failures++;
            end else begin
               e = expected_volumes.pop_front();
               if (rsp_volume_kind !== e.kind) begin
                  $error("volume_kind: expected %0d, got %0d", e.kind, rsp_volume_kind);
                  failures++;
               end
               if (rsp_near_plane !== e.near_v) begin
                  $error("near_plane: expected %0d, got %0d", e.near_v, rsp_near_plane);
                  failures++;
               end
               if (rsp_far_plane !== e.far_v) begin
                  $error("far_plane: expected %0d, got %0d", e.far_v, rsp_far_plane);
                  failures++;
               end
               if (rsp_top_edge !== e.top_v) begin
                  $error("top_edge: expected %0d, got %0d", e.top_v, rsp_top_edge);
                  failures++;
               end
               if (rsp_bottom_edge !== e.bot_v) begin
                  $error("bottom_edge: expected %0d, got %0d", e.bot_v, rsp_bottom_edge);
                  failures++;
               end
               if (rsp_left_edge !== e.left_v) begin
                  $error("left_edge: expected %0d, got %0d", e.left_v, rsp_left_edge);
                  failures++;
               end
               if (rsp_right_edge !== e.right_v) begin
                  $error("right_edge: expected %0d, got %0d", e.right_v, rsp_right_edge);
                  failures++;
               end
               if (rsp_divide_fault !== e.fault) begin
                  $error("divide_fault: expected %0d, got %0d", e.fault, rsp_divide_fault);
                  failures++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog and end of run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else if (stimulus_done && idle_cycles >= 200) begin
         if (failures == 0 && expected_volumes.size() == 0)
            $display("Test completed successfully");
         else
            $display("Test completed with failures");
         $finish;
      end
   end

endmodule
